FILE: sv/bed_pkg.sv
// package for the backslash escape decoder
// holds the phase enum, the result record and helpers; no dependencies
package bed_pkg;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_ESC   = 2'd1,
        PH_HEX   = 2'd2,
        PH_OCT   = 2'd3
    } phase_t;

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_VT  = 8'h0B;
    localparam logic [7:0] CODE_ESC = 8'h1B;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // decoded output of one input beat
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic       done;
    } bed_rec_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_digit(logic [7:0] c);
        hex_t       h;
        logic [7:0] l;
        logic [7:0] d;
        l = c | CASE_BIT;
        h.valid = 1'b0;
        h.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            h.valid = 1'b1;
            h.value = d[3:0];
        end else if (l inside {[8'h61:8'h66]}) begin
            d = l - 8'h57;
            h.valid = 1'b1;
            h.value = d[3:0];
        end
        return h;
    endfunction

    function automatic bed_rec_t rec_put(bed_rec_t r, logic [7:0] b);
        bed_rec_t o;
        o = r;
        case (r.cnt)
            2'd0: o.b0 = b;
            2'd1: o.b1 = b;
            2'd2: o.b2 = b;
            default: ;
        endcase
        if (r.cnt != 2'd3) begin
            o.cnt = r.cnt + 2'd1;
        end
        return o;
    endfunction

endpackage

FILE: sv/bed_front.sv
// front end: escape phase tracking and per-beat decode into a result record
// depends on bed_pkg
module bed_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             acc,
    input  logic [7:0]       in_byte,
    input  logic             string_end,
    output bed_pkg::bed_rec_t rec,
    output logic             push
);

    bed_pkg::phase_t ph_reg, ph_next;
    logic [7:0]      dv_reg, dv_next;
    logic [1:0]      dc_reg, dc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= bed_pkg::PH_PLAIN;
            dv_reg <= 8'd0;
            dc_reg <= 2'd0;
        end else if (acc) begin
            ph_reg <= ph_next;
            dv_reg <= dv_next;
            dc_reg <= dc_next;
        end
    end

    always_comb begin
        bed_pkg::bed_rec_t r;
        bed_pkg::hex_t     h;
        logic              used;
        logic              is_oct;
        logic [7:0]        c;
        logic [7:0]        d;
        c       = in_byte;
        h       = bed_pkg::hex_digit(c);
        is_oct  = c inside {[bed_pkg::CH_ZERO:bed_pkg::CH_SEVEN]};
        d       = c - bed_pkg::CH_ZERO;
        r       = '0;
        used    = 1'b0;
        ph_next = ph_reg;
        dv_next = dv_reg;
        dc_next = dc_reg;

        case (ph_reg)
            bed_pkg::PH_HEX: begin
                if (h.valid) begin
                    dv_next = {dv_reg[3:0], h.value};
                    dc_next = dc_reg + 2'd1;
                    if (dc_next >= 2'd2) begin
                        r = bed_pkg::rec_put(r, dv_next);
                        ph_next = bed_pkg::PH_PLAIN;
                    end
                    used = 1'b1;
                end else begin
                    if (dc_reg == 2'd0) begin
                        r = bed_pkg::rec_put(r, bed_pkg::CH_BSL);
                        r = bed_pkg::rec_put(r, bed_pkg::CH_X);
                    end else begin
                        r = bed_pkg::rec_put(r, dv_reg);
                    end
                    ph_next = bed_pkg::PH_PLAIN;
                end
            end
            bed_pkg::PH_OCT: begin
                if (is_oct) begin
                    dv_next = {dv_reg[4:0], d[2:0]};
                    dc_next = dc_reg + 2'd1;
                    if (dc_next == 2'd3 || dc_next == 2'd0) begin
                        r = bed_pkg::rec_put(r, dv_next);
                        ph_next = bed_pkg::PH_PLAIN;
                    end
                    used = 1'b1;
                end else begin
                    r = bed_pkg::rec_put(r, dv_reg);
                    ph_next = bed_pkg::PH_PLAIN;
                end
            end
            default: ;
        endcase

        if (!used) begin
            if (ph_next == bed_pkg::PH_ESC) begin
                ph_next = bed_pkg::PH_PLAIN;
                case (c)
                    bed_pkg::CH_N:   r = bed_pkg::rec_put(r, bed_pkg::CODE_LF);
                    bed_pkg::CH_T:   r = bed_pkg::rec_put(r, bed_pkg::CODE_TAB);
                    bed_pkg::CH_R:   r = bed_pkg::rec_put(r, bed_pkg::CODE_CR);
                    bed_pkg::CH_A:   r = bed_pkg::rec_put(r, bed_pkg::CODE_BEL);
                    bed_pkg::CH_B:   r = bed_pkg::rec_put(r, bed_pkg::CODE_BS);
                    bed_pkg::CH_F:   r = bed_pkg::rec_put(r, bed_pkg::CODE_FF);
                    bed_pkg::CH_V:   r = bed_pkg::rec_put(r, bed_pkg::CODE_VT);
                    bed_pkg::CH_E:   r = bed_pkg::rec_put(r, bed_pkg::CODE_ESC);
                    bed_pkg::CH_BSL: r = bed_pkg::rec_put(r, bed_pkg::CH_BSL);
                    bed_pkg::CH_X: begin
                        ph_next = bed_pkg::PH_HEX;
                        dv_next = 8'd0;
                        dc_next = 2'd0;
                    end
                    bed_pkg::CH_ZERO: begin
                        ph_next = bed_pkg::PH_OCT;
                        dv_next = 8'd0;
                        dc_next = 2'd0;
                    end
                    default: begin
                        if (c inside {[bed_pkg::CH_ONE:bed_pkg::CH_SEVEN]}) begin
                            ph_next = bed_pkg::PH_OCT;
                            dv_next = {5'd0, d[2:0]};
                            dc_next = 2'd1;
                        end else begin
                            r = bed_pkg::rec_put(r, bed_pkg::CH_BSL);
                            r = bed_pkg::rec_put(r, c);
                        end
                    end
                endcase
            end else if (c == bed_pkg::CH_BSL) begin
                ph_next = bed_pkg::PH_ESC;
            end else begin
                r = bed_pkg::rec_put(r, c);
            end
        end

        // flush at string end
        if (string_end) begin
            if (ph_next == bed_pkg::PH_ESC) begin
                r = bed_pkg::rec_put(r, bed_pkg::CH_BSL);
            end else if (ph_next == bed_pkg::PH_HEX && dc_next == 2'd0) begin
                r = bed_pkg::rec_put(r, bed_pkg::CH_BSL);
                r = bed_pkg::rec_put(r, bed_pkg::CH_X);
            end else if (ph_next != bed_pkg::PH_PLAIN) begin
                r = bed_pkg::rec_put(r, dv_next);
            end
            ph_next = bed_pkg::PH_PLAIN;
            dv_next = 8'd0;
            dc_next = 2'd0;
        end

        r.done = string_end;
        rec    = r;
    end

    assign push = acc && (rec.cnt != 2'd0);

endmodule

FILE: sv/bed_queue.sv
// short record queue between the decode front and the output back end
// depends on bed_pkg
module bed_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  bed_pkg::bed_rec_t wr_rec,
    input  logic             pop,
    output bed_pkg::bed_rec_t rd_rec,
    output logic             empty,
    output logic             full
);

    bed_pkg::bed_rec_t         mem [bed_pkg::QDEPTH];
    logic [bed_pkg::QAW-1:0]   wp_reg, wp_next;
    logic [bed_pkg::QAW-1:0]   rp_reg, rp_next;
    logic [bed_pkg::QAW:0]     cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= wr_rec;
        end
    end

    always_comb begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    assign rd_rec = mem[rp_reg];
    assign empty  = (cnt_reg == '0);
    assign full   = (cnt_reg == (bed_pkg::QAW+1)'(bed_pkg::QDEPTH));

endmodule

FILE: sv/bed_back.sv
// back end: splits each queued record into output beats with last/done flags
// depends on bed_pkg
module bed_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  bed_pkg::bed_rec_t rec,
    input  logic             empty,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_run_last,
    output logic             m_text_done
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       done_reg, done_next;
    logic       load;
    logic       is_last;

    always_comb begin
        load       = !empty && (!valid_reg || m_ready);
        is_last    = (idx_reg == rec.cnt - 2'd1);
        valid_next = valid_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            case (idx_reg)
                2'd0:    byte_next = rec.b0;
                2'd1:    byte_next = rec.b1;
                default: byte_next = rec.b2;
            endcase
            last_next = is_last;
            done_next = is_last && rec.done;
            if (is_last) begin
                pop      = 1'b1;
                idx_next = 2'd0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_run_last  = last_reg;
    assign m_text_done = done_reg;

endmodule

FILE: sv/backslash_escape_decoder_unit.sv
// backslash escape decoder, top level
// depends on bed_pkg, bed_front, bed_queue, bed_back
//
// input channel (s_): one raw text byte per beat, s_string_end on the last
// byte of a string. output channel (m_): one decoded byte per beat;
// m_run_last marks the last beat produced by an input byte, m_text_done the
// last beat of a whole string. an input byte yields zero to three beats.
// the front decodes one input beat per cycle while the queue is not full and
// writes its results as one record into a four-entry queue; the back end
// emits one beat per cycle when m_ready is high. throughput: one input
// beat per cycle while each byte yields at most one output beat and m_ready
// is high; bytes that yield two or three beats hold the output for each
// beat, and the input keeps flowing until the queue fills. s_ready depends
// only on queue occupancy, so an m_ready stall reaches the input after four
// records are waiting. reset (aresetn low, synchronous) empties the queue,
// drops the output beat and returns to plain text.
module backslash_escape_decoder_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_string_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_text_done
);

    bed_pkg::bed_rec_t fr_rec;
    bed_pkg::bed_rec_t q_rec;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    logic              acc;

    assign s_ready = !q_full;
    assign acc     = s_valid && s_ready;

    bed_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .acc        (acc),
        .in_byte    (s_in_byte),
        .string_end (s_string_end),
        .rec        (fr_rec),
        .push       (push)
    );

    bed_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_rec  (fr_rec),
        .pop     (pop),
        .rd_rec  (q_rec),
        .empty   (q_empty),
        .full    (q_full)
    );

    bed_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rec         (q_rec),
        .empty       (q_empty),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last),
        .m_text_done (m_text_done)
    );

endmodule
